>>> rtl/byte_stream_lexer_unit_assert.svh
`ifndef BYTE_STREAM_LEXER_UNIT_ASSERT_SVH
`define BYTE_STREAM_LEXER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer assertion failed");

`endif

>>> rtl/bsl_pkg.sv
package bsl_pkg;

  typedef enum logic [9:0] {
    MODE_IDLE       = 10'b00_0000_0001,
    MODE_SLASH      = 10'b00_0000_0010,
    MODE_MINUS      = 10'b00_0000_0100,
    MODE_LINE       = 10'b00_0000_1000,
    MODE_BLOCK      = 10'b00_0001_0000,
    MODE_BLOCK_STAR = 10'b00_0010_0000,
    MODE_STRING     = 10'b00_0100_0000,
    MODE_STRING_ESC = 10'b00_1000_0000,
    MODE_NUMBER     = 10'b01_0000_0000,
    MODE_IDENT      = 10'b10_0000_0000
  } mode_t;

  localparam logic [4:0] K_UNKNOWN = 5'd0;
  localparam logic [4:0] K_LPAREN  = 5'd1;
  localparam logic [4:0] K_RPAREN  = 5'd2;
  localparam logic [4:0] K_COLON   = 5'd3;
  localparam logic [4:0] K_SEMI    = 5'd4;
  localparam logic [4:0] K_STAR    = 5'd5;
  localparam logic [4:0] K_LBRACK  = 5'd6;
  localparam logic [4:0] K_RBRACK  = 5'd7;
  localparam logic [4:0] K_LBRACE  = 5'd8;
  localparam logic [4:0] K_RBRACE  = 5'd9;
  localparam logic [4:0] K_MINUS   = 5'd10;
  localparam logic [4:0] K_COMMA   = 5'd11;
  localparam logic [4:0] K_STRING  = 5'd12;
  localparam logic [4:0] K_NUMBER  = 5'd13;
  localparam logic [4:0] K_IDENT   = 5'd14;
  localparam logic [4:0] K_EOL     = 5'd15;
  localparam logic [4:0] K_EOS     = 5'd16;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  function automatic token_t mk_tok(input logic [4:0] kind, input logic [31:0] start,
                                    input logic [15:0] length);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

>>> rtl/byte_stream_lexer_unit.sv
// byte stream lexer: text bytes in, tokens out
// in_*  : one text byte per transfer; byte 0 ends the stream and
//         returns the byte offset to zero
// out_* : one token per transfer (start offset and length on tdata,
//         kind on tuser); out_tlast marks the final token caused by one input byte
// tokens are registered in the token queue with the byte that ends them
// throughput: one byte per cycle while in_tready is high; the scan of a byte is
//   a single pass of mode logic, and its tokens go into a four-entry token queue
// a byte that closes a token and is itself a one-byte token gives two tokens;
//   the queue drains one token per cycle while out_tready is high, so a run
//   of such bytes holds in_tready low once more than two tokens are waiting
// receiver stall: tokens collect in the queue and in_tready falls
//   when fewer than two entries are free; nothing is lost
// reset: scanner idle between tokens, offset zero, queue empty
module byte_stream_lexer_unit #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // token_start, token_length
  output logic [4:0]  out_tuser,  // token_kind
  output logic        out_tlast   // last_of_run
);

  localparam int CNT_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

  bsl_pkg::mode_t   mode_r;
  bsl_pkg::mode_t   mode_nxt;
  logic [31:0]      origin_r;
  logic [31:0]      origin_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [31:0]      pos_r;
  logic [31:0]      pos_nxt;
  logic [1:0]       tok_n;
  logic [1:0]       push_n;
  bsl_pkg::token_t  tok0;
  bsl_pkg::token_t  tok1;
  bsl_pkg::token_t  head;
  logic             in_xfer;

  assign in_xfer = in_tvalid && in_tready;
  assign push_n  = in_xfer ? tok_n : 2'd0;

  bsl_scan #(
    .CNT_W (CNT_W)
  ) u_scan (
    .mode_i   (mode_r),
    .origin_i (origin_r),
    .count_i  (count_r),
    .pos_i    (pos_r),
    .byte_i   (in_tdata),
    .mode_o   (mode_nxt),
    .origin_o (origin_nxt),
    .count_o  (count_nxt),
    .pos_o    (pos_nxt),
    .tok_n_o  (tok_n),
    .tok0_o   (tok0),
    .tok1_o   (tok1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bsl_pkg::MODE_IDLE;
      origin_r <= '0;
      count_r  <= '0;
      pos_r    <= '0;
    end else if (in_xfer) begin
      mode_r   <= mode_nxt;
      origin_r <= origin_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
    end
  end

  bsl_tokq u_tokq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push0      (tok0),
    .push1      (tok1),
    .room       (in_tready),
    .head_valid (out_tvalid),
    .head       (head),
    .head_ready (out_tready)
  );

  assign out_tdata = {head.length, head.start};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

>>> rtl/bsl_scan.sv
module bsl_scan #(
  parameter int CNT_W = 16
) (
  input  bsl_pkg::mode_t     mode_i,
  input  logic [31:0]        origin_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [31:0]        pos_i,
  input  logic [7:0]         byte_i,
  output bsl_pkg::mode_t     mode_o,
  output logic [31:0]        origin_o,
  output logic [CNT_W-1:0]   count_o,
  output logic [31:0]        pos_o,
  output logic [1:0]         tok_n_o,
  output bsl_pkg::token_t    tok0_o,
  output bsl_pkg::token_t    tok1_o
);

  logic             is_digit;
  logic             is_alpha;
  logic             is_eol;
  logic [CNT_W-1:0] cnt_inc;
  logic [15:0]      cnt_ext;
  logic             again;
  logic             first_v;
  logic             new_v;
  bsl_pkg::token_t  first_tok;
  bsl_pkg::token_t  new_tok;
  bsl_pkg::token_t  t0;
  bsl_pkg::token_t  t1;

  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign is_alpha = ((byte_i >= 8'h61) && (byte_i <= 8'h7a)) ||
                    ((byte_i >= 8'h41) && (byte_i <= 8'h5a));
  assign is_eol   = (byte_i == bsl_pkg::CH_LF) || (byte_i == bsl_pkg::CH_CR);
  assign cnt_inc  = (count_i == {CNT_W{1'b1}}) ? count_i : count_i + 1'b1;
  assign cnt_ext  = 16'(count_i);
  assign pos_o    = (byte_i == bsl_pkg::CH_NUL) ? 32'd0 : pos_i + 32'd1;

  always_comb begin
    mode_o    = mode_i;
    origin_o  = origin_i;
    count_o   = count_i;
    again     = 1'b0;
    first_v   = 1'b0;
    first_tok = '0;
    new_v     = 1'b0;
    new_tok   = '0;

    // continue the open token or comment
    unique case (mode_i)
      bsl_pkg::MODE_SLASH: begin
        if (byte_i == bsl_pkg::CH_SLASH) begin
          mode_o = bsl_pkg::MODE_LINE;
        end else if (byte_i == bsl_pkg::CH_STAR) begin
          mode_o = bsl_pkg::MODE_BLOCK;
        end else begin
          first_v   = 1'b1;
          first_tok = bsl_pkg::mk_tok(bsl_pkg::K_UNKNOWN, origin_i, 16'd1);
          again     = 1'b1;
        end
      end
      bsl_pkg::MODE_MINUS: begin
        if (is_digit) begin
          mode_o  = bsl_pkg::MODE_NUMBER;
          count_o = CNT_W'(2);
        end else begin
          first_v   = 1'b1;
          first_tok = bsl_pkg::mk_tok(bsl_pkg::K_MINUS, origin_i, 16'd1);
          again     = 1'b1;
        end
      end
      bsl_pkg::MODE_LINE: begin
        again = (byte_i == bsl_pkg::CH_NUL) || is_eol;
      end
      bsl_pkg::MODE_BLOCK: begin
        if (byte_i == bsl_pkg::CH_NUL) begin
          again = 1'b1;
        end else if (byte_i == bsl_pkg::CH_STAR) begin
          mode_o = bsl_pkg::MODE_BLOCK_STAR;
        end
      end
      bsl_pkg::MODE_BLOCK_STAR: begin
        if (byte_i == bsl_pkg::CH_NUL) begin
          again = 1'b1;
        end else if (byte_i == bsl_pkg::CH_SLASH) begin
          mode_o = bsl_pkg::MODE_IDLE;
        end else if (byte_i != bsl_pkg::CH_STAR) begin
          mode_o = bsl_pkg::MODE_BLOCK;
        end
      end
      bsl_pkg::MODE_STRING: begin
        if (byte_i == bsl_pkg::CH_NUL) begin
          first_v   = 1'b1;
          first_tok = bsl_pkg::mk_tok(bsl_pkg::K_STRING, origin_i, cnt_ext);
          again     = 1'b1;
        end else if (byte_i == bsl_pkg::CH_QUOTE) begin
          first_v   = 1'b1;
          first_tok = bsl_pkg::mk_tok(bsl_pkg::K_STRING, origin_i, cnt_ext);
          mode_o    = bsl_pkg::MODE_IDLE;
        end else begin
          count_o = cnt_inc;
          if (byte_i == bsl_pkg::CH_BSLASH) begin
            mode_o = bsl_pkg::MODE_STRING_ESC;
          end
        end
      end
      bsl_pkg::MODE_STRING_ESC: begin
        if (byte_i == bsl_pkg::CH_NUL) begin
          first_v   = 1'b1;
          first_tok = bsl_pkg::mk_tok(bsl_pkg::K_STRING, origin_i, cnt_ext);
          again     = 1'b1;
        end else begin
          count_o = cnt_inc;
          mode_o  = bsl_pkg::MODE_STRING;
        end
      end
      bsl_pkg::MODE_NUMBER: begin
        if (is_digit || (byte_i == bsl_pkg::CH_DOT)) begin
          count_o = cnt_inc;
        end else begin
          first_v   = 1'b1;
          first_tok = bsl_pkg::mk_tok(bsl_pkg::K_NUMBER, origin_i, cnt_ext);
          again     = 1'b1;
        end
      end
      bsl_pkg::MODE_IDENT: begin
        if (is_digit || is_alpha) begin
          count_o = cnt_inc;
        end else begin
          first_v   = 1'b1;
          first_tok = bsl_pkg::mk_tok(bsl_pkg::K_IDENT, origin_i, cnt_ext);
          again     = 1'b1;
        end
      end
      default: begin
        again = 1'b1;
      end
    endcase

    // scan the byte as the start of something new
    if (again) begin
      mode_o = bsl_pkg::MODE_IDLE;
      unique case (byte_i) inside
        bsl_pkg::CH_NUL: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_EOS, pos_i, 16'd1);
        end
        bsl_pkg::CH_LPAREN: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_LPAREN, pos_i, 16'd1);
        end
        bsl_pkg::CH_RPAREN: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_RPAREN, pos_i, 16'd1);
        end
        bsl_pkg::CH_COLON: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_COLON, pos_i, 16'd1);
        end
        bsl_pkg::CH_SEMI: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_SEMI, pos_i, 16'd1);
        end
        bsl_pkg::CH_STAR: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_STAR, pos_i, 16'd1);
        end
        bsl_pkg::CH_LBRACK: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_LBRACK, pos_i, 16'd1);
        end
        bsl_pkg::CH_RBRACK: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_RBRACK, pos_i, 16'd1);
        end
        bsl_pkg::CH_LBRACE: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_LBRACE, pos_i, 16'd1);
        end
        bsl_pkg::CH_RBRACE: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_RBRACE, pos_i, 16'd1);
        end
        bsl_pkg::CH_COMMA: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_COMMA, pos_i, 16'd1);
        end
        bsl_pkg::CH_SPACE, bsl_pkg::CH_TAB, bsl_pkg::CH_VT, bsl_pkg::CH_FF: begin
          new_v = 1'b0;
        end
        bsl_pkg::CH_LF, bsl_pkg::CH_CR: begin
          new_v   = 1'b1;
          new_tok = bsl_pkg::mk_tok(bsl_pkg::K_EOL, pos_i, 16'd1);
        end
        bsl_pkg::CH_QUOTE: begin
          mode_o   = bsl_pkg::MODE_STRING;
          origin_o = pos_i + 32'd1;
          count_o  = '0;
        end
        bsl_pkg::CH_SLASH: begin
          mode_o   = bsl_pkg::MODE_SLASH;
          origin_o = pos_i;
          count_o  = CNT_W'(1);
        end
        bsl_pkg::CH_MINUS: begin
          mode_o   = bsl_pkg::MODE_MINUS;
          origin_o = pos_i;
          count_o  = CNT_W'(1);
        end
        default: begin
          if (is_alpha) begin
            mode_o   = bsl_pkg::MODE_IDENT;
            origin_o = pos_i;
            count_o  = CNT_W'(1);
          end else if (is_digit) begin
            mode_o   = bsl_pkg::MODE_NUMBER;
            origin_o = pos_i;
            count_o  = CNT_W'(1);
          end else begin
            new_v   = 1'b1;
            new_tok = bsl_pkg::mk_tok(bsl_pkg::K_UNKNOWN, pos_i, 16'd1);
          end
        end
      endcase
    end

    // order the tokens and mark the final one
    t0 = first_v ? first_tok : new_tok;
    t1 = new_tok;
    t0.last = !(first_v && new_v);
    t1.last = 1'b1;
  end

  assign tok_n_o = {1'b0, first_v} + {1'b0, new_v};
  assign tok0_o  = t0;
  assign tok1_o  = t1;

endmodule

>>> rtl/bsl_tokq.sv
module bsl_tokq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_n,
  input  bsl_pkg::token_t push0,
  input  bsl_pkg::token_t push1,
  output logic            room,
  output logic            head_valid,
  output bsl_pkg::token_t head,
  input  logic            head_ready
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  bsl_pkg::token_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] wr_nxt;
  logic [PTR_W-1:0] rd_r;
  logic [PTR_W-1:0] rd_nxt;
  logic [PTR_W:0]   fill_r;
  logic [PTR_W:0]   fill_nxt;
  logic             pop;

  assign head_valid = (fill_r != '0);
  assign head       = mem_r[rd_r];
  // two free entries cover the worst case of one byte
  assign room       = (fill_r <= (PTR_W+1)'(DEPTH - 2));
  assign pop        = head_valid && head_ready;

  assign wr_nxt   = wr_r + PTR_W'(push_n);
  assign rd_nxt   = rd_r + PTR_W'(pop);
  assign fill_nxt = fill_r + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_r + PTR_W'(1)] <= push1;
    end
  end

endmodule

>>> rtl/bsl_chk.sv
`include "byte_stream_lexer_unit_assert.svh"

module bsl_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [4:0]  out_tuser,
  input logic        out_tlast
);

  logic [4:0]  kind;
  logic [15:0] length;
  logic        var_len;

  assign kind    = out_tuser;
  assign length  = out_tdata[47:32];
  assign var_len = (kind == bsl_pkg::K_STRING) || (kind == bsl_pkg::K_NUMBER) ||
                   (kind == bsl_pkg::K_IDENT);

  // a stalled token stays offered
  `BSL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // end of stream always yields a token right away
  `BSL_ASSERT_NEXT(a_eos_token, in_tvalid && in_tready && (in_tdata == bsl_pkg::CH_NUL), out_tvalid)
  // end of stream closes the run of its byte
  `BSL_ASSERT_NOW(a_eos_last, out_tvalid && (kind == bsl_pkg::K_EOS), out_tlast)
  // fixed tokens are one byte long
  `BSL_ASSERT_NOW(a_fixed_len, out_tvalid && !var_len, length == 16'd1)

endmodule

bind byte_stream_lexer_unit bsl_chk u_bsl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> tb/tb_byte_stream_lexer_unit.sv
module tb_byte_stream_lexer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LB = 16;
  localparam logic [15:0] LEN_CAP = (LB >= 16) ? 16'hffff : 16'((1 << LB) - 1);
  localparam int RANDOM_BYTES = 790;
  localparam int LONG_STRING_BYTES = 120;
  localparam int TAIL_BYTES = 100;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  byte_stream_lexer_unit #(.LENGTH_BITS(LB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  logic [7:0]      pending_bytes[$];
  bsl_pkg::token_t expected_tokens[$];
  bsl_pkg::token_t step_toks[$];
  int              errors = 0;

  bsl_pkg::mode_t scan_st = bsl_pkg::MODE_IDLE;
  logic [31:0]    tok_origin = '0;
  logic [15:0]    tok_len = '0;
  logic [31:0]    byte_pos = '0;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  task automatic add_tok(input logic [4:0] kind, input logic [31:0] start,
                         input logic [15:0] len);
    bsl_pkg::token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.last   = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic count_up();
    if (tok_len < LEN_CAP) tok_len = tok_len + 16'd1;
  endtask

  task automatic scan_fresh(input logic [7:0] b, input logic [31:0] pos);
    scan_st = bsl_pkg::MODE_IDLE;
    case (b)
      bsl_pkg::CH_NUL:    add_tok(bsl_pkg::K_EOS, pos, 16'd1);
      bsl_pkg::CH_LPAREN: add_tok(bsl_pkg::K_LPAREN, pos, 16'd1);
      bsl_pkg::CH_RPAREN: add_tok(bsl_pkg::K_RPAREN, pos, 16'd1);
      bsl_pkg::CH_COLON:  add_tok(bsl_pkg::K_COLON, pos, 16'd1);
      bsl_pkg::CH_SEMI:   add_tok(bsl_pkg::K_SEMI, pos, 16'd1);
      bsl_pkg::CH_STAR:   add_tok(bsl_pkg::K_STAR, pos, 16'd1);
      bsl_pkg::CH_LBRACK: add_tok(bsl_pkg::K_LBRACK, pos, 16'd1);
      bsl_pkg::CH_RBRACK: add_tok(bsl_pkg::K_RBRACK, pos, 16'd1);
      bsl_pkg::CH_LBRACE: add_tok(bsl_pkg::K_LBRACE, pos, 16'd1);
      bsl_pkg::CH_RBRACE: add_tok(bsl_pkg::K_RBRACE, pos, 16'd1);
      bsl_pkg::CH_COMMA:  add_tok(bsl_pkg::K_COMMA, pos, 16'd1);
      bsl_pkg::CH_SPACE, bsl_pkg::CH_TAB, bsl_pkg::CH_VT, bsl_pkg::CH_FF: ;
      bsl_pkg::CH_LF, bsl_pkg::CH_CR: add_tok(bsl_pkg::K_EOL, pos, 16'd1);
      bsl_pkg::CH_QUOTE: begin
        scan_st = bsl_pkg::MODE_STRING;
        tok_origin = pos + 32'd1;
        tok_len = 16'd0;
      end
      bsl_pkg::CH_SLASH: begin
        scan_st = bsl_pkg::MODE_SLASH;
        tok_origin = pos;
        tok_len = 16'd1;
      end
      bsl_pkg::CH_MINUS: begin
        scan_st = bsl_pkg::MODE_MINUS;
        tok_origin = pos;
        tok_len = 16'd1;
      end
      default: begin
        if (is_alpha(b)) begin
          scan_st = bsl_pkg::MODE_IDENT;
          tok_origin = pos;
          tok_len = 16'd1;
        end else if (is_digit(b)) begin
          scan_st = bsl_pkg::MODE_NUMBER;
          tok_origin = pos;
          tok_len = 16'd1;
        end else begin
          add_tok(bsl_pkg::K_UNKNOWN, pos, 16'd1);
        end
      end
    endcase
  endtask

  task automatic lex_byte(input logic [7:0] b);
    logic        rescan;
    logic [31:0] pos;
    pos = byte_pos;
    rescan = 1'b0;
    step_toks.delete();
    case (scan_st)
      bsl_pkg::MODE_SLASH: begin
        if (b == bsl_pkg::CH_SLASH) scan_st = bsl_pkg::MODE_LINE;
        else if (b == bsl_pkg::CH_STAR) scan_st = bsl_pkg::MODE_BLOCK;
        else begin
          add_tok(bsl_pkg::K_UNKNOWN, tok_origin, 16'd1);
          rescan = 1'b1;
        end
      end
      bsl_pkg::MODE_MINUS: begin
        if (is_digit(b)) begin
          scan_st = bsl_pkg::MODE_NUMBER;
          tok_len = 16'd2;
        end else begin
          add_tok(bsl_pkg::K_MINUS, tok_origin, 16'd1);
          rescan = 1'b1;
        end
      end
      bsl_pkg::MODE_LINE: begin
        if (b == bsl_pkg::CH_NUL || b == bsl_pkg::CH_LF || b == bsl_pkg::CH_CR) rescan = 1'b1;
      end
      bsl_pkg::MODE_BLOCK: begin
        if (b == bsl_pkg::CH_NUL) rescan = 1'b1;
        else if (b == bsl_pkg::CH_STAR) scan_st = bsl_pkg::MODE_BLOCK_STAR;
      end
      bsl_pkg::MODE_BLOCK_STAR: begin
        if (b == bsl_pkg::CH_NUL) rescan = 1'b1;
        else if (b == bsl_pkg::CH_SLASH) scan_st = bsl_pkg::MODE_IDLE;
        else if (b != bsl_pkg::CH_STAR) scan_st = bsl_pkg::MODE_BLOCK;
      end
      bsl_pkg::MODE_STRING: begin
        if (b == bsl_pkg::CH_NUL) begin
          add_tok(bsl_pkg::K_STRING, tok_origin, tok_len);
          rescan = 1'b1;
        end else if (b == bsl_pkg::CH_QUOTE) begin
          add_tok(bsl_pkg::K_STRING, tok_origin, tok_len);
          scan_st = bsl_pkg::MODE_IDLE;
        end else begin
          count_up();
          if (b == bsl_pkg::CH_BSLASH) scan_st = bsl_pkg::MODE_STRING_ESC;
        end
      end
      bsl_pkg::MODE_STRING_ESC: begin
        if (b == bsl_pkg::CH_NUL) begin
          add_tok(bsl_pkg::K_STRING, tok_origin, tok_len);
          rescan = 1'b1;
        end else begin
          count_up();
          scan_st = bsl_pkg::MODE_STRING;
        end
      end
      bsl_pkg::MODE_NUMBER: begin
        if (is_digit(b) || b == bsl_pkg::CH_DOT) count_up();
        else begin
          add_tok(bsl_pkg::K_NUMBER, tok_origin, tok_len);
          rescan = 1'b1;
        end
      end
      bsl_pkg::MODE_IDENT: begin
        if (is_digit(b) || is_alpha(b)) count_up();
        else begin
          add_tok(bsl_pkg::K_IDENT, tok_origin, tok_len);
          rescan = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase
    if (rescan) scan_fresh(b, pos);
    byte_pos = (b == bsl_pkg::CH_NUL) ? 32'd0 : pos + 32'd1;
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endtask

  // input side
  int   in_gap = 0;
  logic in_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      scan_st    = bsl_pkg::MODE_IDLE;
      tok_origin = '0;
      tok_len    = '0;
      byte_pos   = '0;
    end else begin
      if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) lex_byte(in_tdata);
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!in_calm && pending_bytes.size() > TAIL_BYTES &&
                     $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes.pop_front();
        end
      end
    end
  end

  // output side
  int   out_stall = 0;
  logic out_calm = 1'b0;

  always @(posedge clk) begin
    bsl_pkg::token_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected token: kind %0d start %0d len %0d last %0b",
                     out_tuser, out_tdata[31:0], out_tdata[47:32], out_tlast);
        end else begin
          want = expected_tokens.pop_front();
          if (out_tuser !== want.kind || out_tdata[31:0] !== want.start ||
              out_tdata[47:32] !== want.length || out_tlast !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("token mismatch: expected kind %0d start %0d len %0d last %0b, %s",
                       want.kind, want.start, want.length, want.last,
                       $sformatf("got kind %0d start %0d len %0d last %0b",
                                 out_tuser, out_tdata[31:0], out_tdata[47:32],
                                 out_tlast));
          end
        end
      end
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (!out_calm && pending_bytes.size() > TAIL_BYTES &&
                   $urandom_range(0, 4) == 0) begin
        out_stall = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    return 8'("A" + r - 36);
  endfunction

  function automatic logic [7:0] rand_printable();
    logic [7:0] b;
    b = 8'($urandom_range(32, 126));
    if (b == bsl_pkg::CH_QUOTE || b == bsl_pkg::CH_BSLASH) b = "q";
    return b;
  endfunction

  task automatic put_string_body(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        put_byte(bsl_pkg::CH_BSLASH);
        put_byte(8'($urandom_range(1, 255)));
      end else begin
        put_byte(rand_printable());
      end
    end
  endtask

  task automatic put_random_text();
    logic [7:0] punct[10];
    logic [7:0] blank[4];
    logic [7:0] b;
    int         n;
    punct = '{bsl_pkg::CH_LPAREN, bsl_pkg::CH_RPAREN, bsl_pkg::CH_COLON, bsl_pkg::CH_SEMI,
              bsl_pkg::CH_STAR, bsl_pkg::CH_LBRACK, bsl_pkg::CH_RBRACK, bsl_pkg::CH_LBRACE,
              bsl_pkg::CH_RBRACE, bsl_pkg::CH_COMMA};
    blank = '{bsl_pkg::CH_SPACE, bsl_pkg::CH_TAB, bsl_pkg::CH_VT, bsl_pkg::CH_FF};
    case ($urandom_range(0, 15))
      0, 1: put_byte(punct[$urandom_range(0, 9)]);
      2, 14: put_byte(blank[$urandom_range(0, 3)]);
      3, 4, 15: begin
        b = rand_alnum();
        put_byte(is_digit(b) ? 8'("k") : b);
        n = $urandom_range(0, 6);
        repeat (n) put_byte(rand_alnum());
      end
      5: begin
        if ($urandom_range(0, 1)) put_byte(bsl_pkg::CH_MINUS);
        put_byte(8'($urandom_range("0", "9")));
        n = $urandom_range(0, 5);
        repeat (n) put_byte($urandom_range(0, 3) == 0 ? bsl_pkg::CH_DOT :
                            8'($urandom_range("0", "9")));
      end
      6: begin
        put_byte(bsl_pkg::CH_QUOTE);
        put_string_body($urandom_range(0, 8));
        if ($urandom_range(0, 7) != 0) put_byte(bsl_pkg::CH_QUOTE);
        else put_byte(bsl_pkg::CH_NUL);
      end
      7: begin
        put_str("//");
        n = $urandom_range(0, 6);
        repeat (n) begin
          b = 8'($urandom_range(1, 255));
          put_byte((b == bsl_pkg::CH_LF || b == bsl_pkg::CH_CR) ? 8'("x") : b);
        end
        put_byte($urandom_range(0, 1) ? bsl_pkg::CH_CR : bsl_pkg::CH_LF);
      end
      8: begin
        put_str("/*");
        n = $urandom_range(0, 8);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: put_byte(bsl_pkg::CH_STAR);
            1: put_byte(bsl_pkg::CH_SLASH);
            default: put_byte(8'($urandom_range(1, 255)));
          endcase
        end
        if ($urandom_range(0, 7) != 0) put_str("*/");
        else put_byte(bsl_pkg::CH_NUL);
      end
      9: put_byte($urandom_range(0, 1) ? bsl_pkg::CH_CR : bsl_pkg::CH_LF);
      10: put_byte($urandom_range(0, 1) ? bsl_pkg::CH_SLASH : bsl_pkg::CH_MINUS);
      11: begin
        case ($urandom_range(0, 2))
          0: put_byte(bsl_pkg::CH_DOT);
          1: put_byte(8'($urandom_range(128, 255)));
          default: put_byte("#");
        endcase
      end
      12: put_byte(8'($urandom_range(0, 255)));
      13: put_byte(bsl_pkg::CH_NUL);
    endcase
  endtask

  initial begin
    int base;
    put_str("(){}[]:;*,-1.-a/x/*/*/\"\\\"\"//c");
    put_byte(bsl_pkg::CH_CR);
    put_byte(bsl_pkg::CH_LF);
    put_str(" \t\v\f");
    put_byte(8'hff);
    put_str("z");
    put_byte(bsl_pkg::CH_NUL);
    // a long string
    put_byte(bsl_pkg::CH_QUOTE);
    repeat (LONG_STRING_BYTES) put_byte(rand_printable());
    put_byte(bsl_pkg::CH_QUOTE);
    put_byte(bsl_pkg::CH_NUL);
    base = pending_bytes.size();
    while (pending_bytes.size() - base < RANDOM_BYTES) put_random_text();
    put_byte(bsl_pkg::CH_NUL);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_tokens.size() != 0) errors++;
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> byte_stream_lexer_unit.f
+incdir+rtl
rtl/bsl_pkg.sv
rtl/bsl_scan.sv
rtl/bsl_tokq.sv
rtl/byte_stream_lexer_unit.sv
rtl/bsl_chk.sv
tb/tb_byte_stream_lexer_unit.sv
